// ----- hw/rtl/bvos_pkg.sv -----
// bvos_pkg: shared constants, codes and types of the volume overlap scan unit
// used by the front, queue, back and top level files
`default_nettype none

package bvos_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DATA_W  = 32;
  localparam int SLOT_W  = 6;
  localparam int WSEL_W  = 3;
  localparam int CTRL_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int HEIGHT_W  = 31;

  // word select codes
  localparam logic [WSEL_W-1:0] WSEL_CTRL    = 3'd0;
  localparam logic [WSEL_W-1:0] WSEL_MIN_X   = 3'd1;
  localparam logic [WSEL_W-1:0] WSEL_MAX_X   = 3'd2;
  localparam logic [WSEL_W-1:0] WSEL_MIN_Y   = 3'd3;
  localparam logic [WSEL_W-1:0] WSEL_MAX_Y   = 3'd4;
  localparam logic [WSEL_W-1:0] WSEL_LOWER_Z = 3'd5;
  localparam logic [WSEL_W-1:0] WSEL_TOP_Z   = 3'd6;
  localparam logic [WSEL_W-1:0] WSEL_UNUSED  = 3'd7;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_X_OFS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X_OFS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y_OFS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y_OFS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd5;

  // control word layout
  localparam int CTRL_END_BIT     = 0;
  localparam int CTRL_TYPE_LSB    = 1;
  localparam int CTRL_TYPE_MSB    = 4;
  localparam int CTRL_ENABLE_BIT  = 5;
  localparam int CTRL_EXCLUDE_BIT = 6;
  localparam logic [3:0] VOLUME_TYPE = 4'd3;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IDX_W-1:0]         slot;
    logic [WSEL_W-1:0]        wsel;
    logic [DATA_W-1:0]        wval;
    logic signed [DATA_W-1:0] bx0;
    logic signed [DATA_W-1:0] bx1;
    logic signed [DATA_W-1:0] by0;
    logic signed [DATA_W-1:0] by1;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] ztop;
    logic signed [DATA_W-1:0] lim;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bvos_front.sv -----
// bvos_front: accepts input items, holds the configuration registers and
// turns each item into a job for the queue, but drops a table write with the unused word select; depends on bvos_pkg
`default_nettype none

module bvos_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bvos_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bvos_pkg::DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              kind_i,
  input  wire logic [bvos_pkg::SLOT_W-1:0]       slot_i,
  input  wire logic [bvos_pkg::WSEL_W-1:0]       word_select_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] word_value_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_x_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_y_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_z_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] scan_limit_i,
  input  wire bvos_pkg::q_stat_t                 q_stat_i,
  output logic                                   push_o,
  output bvos_pkg::job_t                         job_o
);
  import bvos_pkg::*;

  logic                     surfaces_q;
  logic signed [DATA_W-1:0] min_x_ofs_q;
  logic signed [DATA_W-1:0] max_x_ofs_q;
  logic signed [DATA_W-1:0] min_y_ofs_q;
  logic signed [DATA_W-1:0] max_y_ofs_q;
  logic [HEIGHT_W-1:0]      height_q;

  logic slot_ok;
  logic drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surfaces_q  <= 1'b0;
      min_x_ofs_q <= '0;
      max_x_ofs_q <= '0;
      min_y_ofs_q <= '0;
      max_y_ofs_q <= '0;
      height_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SURFACES:  surfaces_q  <= cfg_wdata_i[0];
        CFG_MIN_X_OFS: min_x_ofs_q <= $signed(cfg_wdata_i);
        CFG_MAX_X_OFS: max_x_ofs_q <= $signed(cfg_wdata_i);
        CFG_MIN_Y_OFS: min_y_ofs_q <= $signed(cfg_wdata_i);
        CFG_MAX_Y_OFS: max_y_ofs_q <= $signed(cfg_wdata_i);
        CFG_HEIGHT:    height_q    <= cfg_wdata_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign slot_ok    = (32'(slot_i) < 32'(TABLE_DEPTH));
  assign drop       = (kind_i == KIND_WRITE) && (!slot_ok || (word_select_i == WSEL_UNUSED));
  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o && !drop;

  always_comb begin
    job_o.slot = IDX_W'(slot_i);
    job_o.wsel = word_select_i;
    job_o.wval = word_value_i;
    job_o.bx0  = pos_x_i + min_x_ofs_q;
    job_o.bx1  = pos_x_i + max_x_ofs_q;
    job_o.by0  = pos_y_i + min_y_ofs_q;
    job_o.by1  = pos_y_i + max_y_ofs_q;
    job_o.z    = pos_z_i;
    job_o.ztop = pos_z_i + $signed({1'b0, height_q});
    job_o.lim  = scan_limit_i;
    if (kind_i == KIND_WRITE) begin
      job_o.op = OP_WRITE;
    end else if (!surfaces_q || !slot_ok) begin
      job_o.op = OP_CLEAR;
    end else begin
      job_o.op = OP_QUERY;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bvos_queue.sv -----
// bvos_queue: short job queue between front and back
// depends on bvos_pkg for the job type and depth
`default_nettype none

module bvos_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bvos_pkg::job_t    job_i,
  input  wire logic              pop_i,
  output bvos_pkg::job_t         head_o,
  output bvos_pkg::q_stat_t      stat_o
);
  import bvos_pkg::*;

  job_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bvos_back.sv -----
// bvos_back: volume table memory, table writes and the query scan
// with the result register; depends on bvos_pkg
`default_nettype none

module bvos_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bvos_pkg::job_t    head_i,
  input  wire bvos_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   path_clear_o
);
  import bvos_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  logic [CTRL_W-1:0] mem_ctrl  [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_min_x [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_max_x [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_min_y [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_max_y [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_low_z [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_top_z [TABLE_DEPTH];

  logic [CTRL_W-1:0]        rd_ctrl_q;
  logic signed [DATA_W-1:0] rd_min_x_q, rd_max_x_q, rd_min_y_q, rd_max_y_q;
  logic signed [DATA_W-1:0] rd_low_z_q, rd_top_z_q;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic             path_clear_q;

  logic             head_valid, out_free, mem_we, res_set;
  logic [IDX_W-1:0] rd_addr;
  logic             stop_end, stop_lim, considered, covers;
  logic             x_span, y_span, x_edge, y_edge, hit, done;

  assign head_valid = !q_stat_i.empty;
  assign out_free   = !out_valid_q || out_ready_i;
  assign mem_we     = (state_q == ST_IDLE) && head_valid && (head_i.op == OP_WRITE);
  assign rd_addr    = (state_q == ST_SCAN) ? idx_q + IDX_W'(1) : head_i.slot;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      case (head_i.wsel)
        WSEL_CTRL:    mem_ctrl[head_i.slot]  <= head_i.wval[CTRL_W-1:0];
        WSEL_MIN_X:   mem_min_x[head_i.slot] <= head_i.wval;
        WSEL_MAX_X:   mem_max_x[head_i.slot] <= head_i.wval;
        WSEL_MIN_Y:   mem_min_y[head_i.slot] <= head_i.wval;
        WSEL_MAX_Y:   mem_max_y[head_i.slot] <= head_i.wval;
        WSEL_LOWER_Z: mem_low_z[head_i.slot] <= head_i.wval;
        WSEL_TOP_Z:   mem_top_z[head_i.slot] <= head_i.wval;
        default: ;
      endcase
    end
    rd_ctrl_q  <= mem_ctrl[rd_addr];
    rd_min_x_q <= $signed(mem_min_x[rd_addr]);
    rd_max_x_q <= $signed(mem_max_x[rd_addr]);
    rd_min_y_q <= $signed(mem_min_y[rd_addr]);
    rd_max_y_q <= $signed(mem_max_y[rd_addr]);
    rd_low_z_q <= $signed(mem_low_z[rd_addr]);
    rd_top_z_q <= $signed(mem_top_z[rd_addr]);
  end

  // entry check against the entity box
  always_comb begin
    stop_end   = rd_ctrl_q[CTRL_END_BIT];
    stop_lim   = (rd_min_x_q >= head_i.lim);
    considered = (rd_ctrl_q[CTRL_TYPE_MSB:CTRL_TYPE_LSB] == VOLUME_TYPE)
                 && rd_ctrl_q[CTRL_ENABLE_BIT] && !rd_ctrl_q[CTRL_EXCLUDE_BIT]
                 && !(head_i.z < rd_low_z_q) && !(head_i.ztop > rd_top_z_q);
    covers = (rd_min_x_q <= head_i.bx0) && (rd_max_x_q >= head_i.bx1)
             && (rd_min_y_q <= head_i.by0) && (rd_max_y_q >= head_i.by1);
    x_span = ((rd_min_x_q <= head_i.bx0) && (rd_max_x_q > head_i.bx0))
             || ((rd_min_x_q < head_i.bx1) && (rd_max_x_q >= head_i.bx1));
    y_edge = ((rd_min_y_q >= head_i.by0) && (rd_min_y_q < head_i.by1))
             || ((rd_max_y_q > head_i.by0) && (rd_max_y_q <= head_i.by1));
    y_span = ((rd_min_y_q <= head_i.by0) && (rd_max_y_q > head_i.by0))
             || ((rd_min_y_q < head_i.by1) && (rd_max_y_q >= head_i.by1));
    x_edge = ((rd_min_x_q >= head_i.bx0) && (rd_min_x_q < head_i.bx1))
             || ((rd_max_x_q > head_i.bx0) && (rd_max_x_q <= head_i.bx1));
    hit    = !stop_end && !stop_lim && considered
             && (covers || (x_span && y_edge) || (y_span && x_edge));
    done   = stop_end || stop_lim || hit || (idx_q == IDX_W'(TABLE_DEPTH - 1));
  end

  // a new result is loaded only when the result register is free
  assign res_set = ((state_q == ST_IDLE) && head_valid && out_free && (head_i.op == OP_CLEAR))
                   || ((state_q == ST_SCAN) && done);

  always_comb begin
    pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_valid) begin
          pop_o = (head_i.op == OP_WRITE) || ((head_i.op == OP_CLEAR) && out_free);
        end
      end
      ST_SCAN: pop_o = done;
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      path_clear_q <= 1'b1;
    end else begin
      if (res_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (head_valid && out_free) begin
            case (head_i.op)
              OP_CLEAR: begin
                path_clear_q <= 1'b1;
              end
              OP_QUERY: begin
                idx_q   <= head_i.slot;
                state_q <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (done) begin
            path_clear_q <= !hit;
            state_q      <= ST_IDLE;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_clear_o = path_clear_q;

endmodule

`default_nettype wire

// ----- hw/rtl/box_volume_overlap_scan_unit.sv -----
// box_volume_overlap_scan_unit: top level joining front, queue and back
// depends on bvos_pkg, bvos_front, bvos_queue and bvos_back
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------------
//   cfg      | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//   in       | in_valid_i / in_ready_o  | kind_i, slot_i, word_select_i, word_value_i,
//            |                          | pos_x_i, pos_y_i, pos_z_i, scan_limit_i
//   out      | out_valid_o / out_ready_i| path_clear_o
//
// a table write, or a query with surfaces off or a start slot past the table, is
// handled in the back's idle state; a scanning query reads the entries it visits in
// turn through the single registered read port of the volume table
// reset clears configuration, queue and result register; table contents stay
// undefined until written
// the two-entry queue keeps accepting, while it is not full, when the back scans or a result waits
`default_nettype none

module box_volume_overlap_scan_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bvos_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bvos_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               kind_i,
  input  wire logic [bvos_pkg::SLOT_W-1:0]        slot_i,
  input  wire logic [bvos_pkg::WSEL_W-1:0]        word_select_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] word_value_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_x_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_y_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] pos_z_i,
  input  wire logic signed [bvos_pkg::DATA_W-1:0] scan_limit_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    path_clear_o
);
  import bvos_pkg::*;

  logic    push, pop;
  job_t    push_job, head_job;
  q_stat_t q_stat;

  bvos_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .slot_i        (slot_i),
    .word_select_i (word_select_i),
    .word_value_i  (word_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .scan_limit_i  (scan_limit_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .job_o         (push_job)
  );

  bvos_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .head_o (head_job),
    .stat_o (q_stat)
  );

  bvos_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .path_clear_o (path_clear_o)
  );

endmodule

`default_nettype wire
